### hdl/cbr_pkg.sv
// cbr_pkg: shared types and constants of the cubic bisection root finder
`timescale 1ns / 1ps
`default_nettype none

package cbr_pkg;

    // precision register width, unsigned fixed point
    localparam int PREC_WIDTH = 31;

    // configuration register index
    localparam int CFG_INDEX_W = 3;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_COEF_CUBIC  = 3'd0;
    localparam cfg_index_t REG_COEF_SQUARE = 3'd1;
    localparam cfg_index_t REG_COEF_LINEAR = 3'd2;
    localparam cfg_index_t REG_COEF_CONST  = 3'd3;
    localparam cfg_index_t REG_PRECISION   = 3'd4;

    // iteration counter width, holds up to 63 steps
    localparam int STEP_W = 6;

    // which coefficient term is added after a horner product
    typedef logic [1:0] coef_sel_t;
    localparam coef_sel_t COEF_SEL_SQUARE = 2'd0;
    localparam coef_sel_t COEF_SEL_LINEAR = 2'd1;
    localparam coef_sel_t COEF_SEL_CONST  = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic      load;        // latch a new bracket
        logic      step_start;  // take midpoint, seed horner value with cubic coef
        logic      mul_bit;     // one shift-add step of the multiplier
        logic      mul_first;   // first (sign) bit of the multiplier
        logic      add_coef;    // add next shifted coefficient to the product
        coef_sel_t coef_sel;
        logic      decide;      // move a bracket end by the sign of p(mid)
        logic      publish;     // copy result into the output register
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic cont;    // half width still at least the precision
        logic v_zero;  // polynomial value is exactly zero
    } status_t;

endpackage : cbr_pkg

`default_nettype wire

### hdl/cbr_ifs.sv
// cbr_ifs: request and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface cbr_in_if #(
    parameter int X_WIDTH = 32
);
    logic                      valid;
    logic                      ready;
    logic signed [X_WIDTH-1:0] left_end;
    logic signed [X_WIDTH-1:0] right_end;

    modport source (output valid, output left_end, output right_end, input ready);
    modport sink   (input valid, input left_end, input right_end, output ready);
endinterface : cbr_in_if

interface cbr_out_if #(
    parameter int X_WIDTH = 32
);
    logic                      valid;
    logic                      ready;
    logic signed [X_WIDTH-1:0] root;
    logic                      exact_zero;
    logic [5:0]                iterations_done;

    modport source (output valid, output root, output exact_zero,
                    output iterations_done, input ready);
    modport sink   (input valid, input root, input exact_zero,
                    input iterations_done, output ready);
endinterface : cbr_out_if

`default_nettype wire

### hdl/cubic_bisection_root_top.sv
// Cubic bisection root finder: a request carries a bracket [left_end, right_end] in signed
// fixed point with X_FRAC_BITS fraction bits; the block bisects it for a root of
// a*x^3 + b*x^2 + c*x + d, with the integer coefficients and the stopping precision held
// in configuration registers 0 to 4 (reset: all coefficients 0, precision 1). Each step
// evaluates the polynomial exactly at the floor midpoint and moves the left end on a
// negative value, the right end on a positive one, and stops with exact_zero on zero;
// steps continue while right - left is at least twice the precision. One request is
// worked on at a time. In each bisection step the three Horner products run through one
// shift-add multiplier at one bit a cycle. A request takes at most X_WIDTH steps. The
// result sits in an output register, so the next request is accepted while it waits to
// be taken.
`timescale 1ns / 1ps
`default_nettype none

module cubic_bisection_root_top #(
    parameter int X_WIDTH     = 32,
    parameter int X_FRAC_BITS = 16,
    parameter int COEF_WIDTH  = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    cbr_in_if.sink                   bracket,
    cbr_out_if.source                result,
    input  wire logic                cfg_write,
    input  wire cbr_pkg::cfg_index_t cfg_index,
    input  wire logic [((COEF_WIDTH > cbr_pkg::PREC_WIDTH) ? COEF_WIDTH
                        : cbr_pkg::PREC_WIDTH)-1:0] cfg_data
);
    import cbr_pkg::*;

    // write data width: the widest register
    localparam int CFG_W = (COEF_WIDTH > PREC_WIDTH) ? COEF_WIDTH : PREC_WIDTH;

    logic signed [COEF_WIDTH-1:0] coef_cubic;
    logic signed [COEF_WIDTH-1:0] coef_square;
    logic signed [COEF_WIDTH-1:0] coef_linear;
    logic signed [COEF_WIDTH-1:0] coef_const;
    logic [PREC_WIDTH-1:0]        precision;
    cmd_t                         cmd;
    status_t                      sts;
    logic                         in_ready;
    logic                         out_valid;

    // configuration registers
    cbr_regs #(
        .COEF_WIDTH (COEF_WIDTH),
        .CFG_W      (CFG_W)
    ) u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .coef_cubic  (coef_cubic),
        .coef_square (coef_square),
        .coef_linear (coef_linear),
        .coef_const  (coef_const),
        .precision   (precision)
    );

    // sequencer
    cbr_ctrl #(
        .X_WIDTH (X_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bracket.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // bracket and evaluation datapath
    cbr_dpath #(
        .X_WIDTH     (X_WIDTH),
        .X_FRAC_BITS (X_FRAC_BITS),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_dpath (
        .clk             (clk),
        .cmd             (cmd),
        .sts             (sts),
        .left_end        (bracket.left_end),
        .right_end       (bracket.right_end),
        .coef_cubic      (coef_cubic),
        .coef_square     (coef_square),
        .coef_linear     (coef_linear),
        .coef_const      (coef_const),
        .precision       (precision),
        .root            (result.root),
        .exact_zero      (result.exact_zero),
        .iterations_done (result.iterations_done)
    );

    assign bracket.ready = in_ready;
    assign result.valid  = out_valid;

endmodule : cubic_bisection_root_top

`default_nettype wire

### hdl/cbr_regs.sv
// cbr_regs: configuration registers (coefficients and precision)
`timescale 1ns / 1ps
`default_nettype none

module cbr_regs #(
    parameter int COEF_WIDTH = 16,
    parameter int CFG_W      = 31
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire cbr_pkg::cfg_index_t            cfg_index,
    input  wire logic [CFG_W-1:0]               cfg_data,
    output logic signed [COEF_WIDTH-1:0]        coef_cubic,
    output logic signed [COEF_WIDTH-1:0]        coef_square,
    output logic signed [COEF_WIDTH-1:0]        coef_linear,
    output logic signed [COEF_WIDTH-1:0]        coef_const,
    output logic [cbr_pkg::PREC_WIDTH-1:0]      precision
);
    import cbr_pkg::*;

    logic [COEF_WIDTH-1:0] cubic_reg,  cubic_next;
    logic [COEF_WIDTH-1:0] square_reg, square_next;
    logic [COEF_WIDTH-1:0] linear_reg, linear_next;
    logic [COEF_WIDTH-1:0] const_reg,  const_next;
    logic [PREC_WIDTH-1:0] prec_reg,   prec_next;

    // register write decode, indexes past the list are dropped
    always_comb
    begin
        cubic_next  = cubic_reg;
        square_next = square_reg;
        linear_next = linear_reg;
        const_next  = const_reg;
        prec_next   = prec_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_COEF_CUBIC:  cubic_next  = cfg_data[COEF_WIDTH-1:0];
                REG_COEF_SQUARE: square_next = cfg_data[COEF_WIDTH-1:0];
                REG_COEF_LINEAR: linear_next = cfg_data[COEF_WIDTH-1:0];
                REG_COEF_CONST:  const_next  = cfg_data[COEF_WIDTH-1:0];
                REG_PRECISION:   prec_next   = cfg_data[PREC_WIDTH-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cubic_reg  <= '0;
            square_reg <= '0;
            linear_reg <= '0;
            const_reg  <= '0;
            prec_reg   <= PREC_WIDTH'(1);
        end
        else
        begin
            cubic_reg  <= cubic_next;
            square_reg <= square_next;
            linear_reg <= linear_next;
            const_reg  <= const_next;
            prec_reg   <= prec_next;
        end
    end

    assign coef_cubic  = $signed(cubic_reg);
    assign coef_square = $signed(square_reg);
    assign coef_linear = $signed(linear_reg);
    assign coef_const  = $signed(const_reg);

    // a zero precision acts as the smallest step
    assign precision = (prec_reg == '0) ? PREC_WIDTH'(1) : prec_reg;

endmodule : cbr_regs

`default_nettype wire

### hdl/cbr_dpath.sv
// cbr_dpath: bracket registers, bit-serial horner evaluator and result register
`timescale 1ns / 1ps
`default_nettype none

module cbr_dpath #(
    parameter int X_WIDTH     = 32,
    parameter int X_FRAC_BITS = 16,
    parameter int COEF_WIDTH  = 16
) (
    input  wire logic                           clk,
    input  wire cbr_pkg::cmd_t                  cmd,
    output cbr_pkg::status_t                    sts,
    input  wire logic signed [X_WIDTH-1:0]      left_end,
    input  wire logic signed [X_WIDTH-1:0]      right_end,
    input  wire logic signed [COEF_WIDTH-1:0]   coef_cubic,
    input  wire logic signed [COEF_WIDTH-1:0]   coef_square,
    input  wire logic signed [COEF_WIDTH-1:0]   coef_linear,
    input  wire logic signed [COEF_WIDTH-1:0]   coef_const,
    input  wire logic [cbr_pkg::PREC_WIDTH-1:0] precision,
    output logic signed [X_WIDTH-1:0]           root,
    output logic                                exact_zero,
    output logic [cbr_pkg::STEP_W-1:0]          iterations_done
);
    import cbr_pkg::*;

    // horner value bound: |p| * 2^(3F) stays below 2^(COEF_WIDTH + 3K)
    localparam int MAG_W  = (X_WIDTH > X_FRAC_BITS) ? X_WIDTH : X_FRAC_BITS + 1;
    localparam int ACC_W  = COEF_WIDTH + 3 * MAG_W + 4;
    localparam int SPAN_W = ((X_WIDTH > PREC_WIDTH) ? X_WIDTH : PREC_WIDTH) + 2;

    logic signed [X_WIDTH-1:0] lo_reg, lo_next;
    logic signed [X_WIDTH-1:0] hi_reg, hi_next;
    logic signed [X_WIDTH-1:0] mid_reg, mid_next;
    logic [X_WIDTH-1:0]        mshift_reg, mshift_next;
    logic signed [ACC_W-1:0]   v_reg, v_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [STEP_W-1:0]         steps_reg, steps_next;
    logic                      exact_reg, exact_next;
    logic signed [X_WIDTH-1:0] out_root_reg, out_root_next;
    logic                      out_exact_reg, out_exact_next;
    logic [STEP_W-1:0]         out_steps_reg, out_steps_next;

    logic signed [X_WIDTH:0]   pair_sum;
    logic signed [X_WIDTH-1:0] half;
    logic signed [SPAN_W-1:0]  span;
    logic signed [SPAN_W-1:0]  twice_eps;
    logic signed [ACC_W-1:0]   addend;
    logic signed [ACC_W-1:0]   base;
    logic signed [ACC_W-1:0]   product;
    logic signed [ACC_W-1:0]   term;
    logic                      v_neg;
    logic                      v_zero;

    // floor of the midpoint: arithmetic shift of the widened sum
    assign pair_sum = {lo_reg[X_WIDTH-1], lo_reg} + {hi_reg[X_WIDTH-1], hi_reg};
    assign half     = pair_sum[X_WIDTH:1];

    // loop test: right - left >= 2 * precision
    assign span = $signed({{(SPAN_W-X_WIDTH){hi_reg[X_WIDTH-1]}}, hi_reg})
                - $signed({{(SPAN_W-X_WIDTH){lo_reg[X_WIDTH-1]}}, lo_reg});
    assign twice_eps = $signed({{(SPAN_W-PREC_WIDTH-1){1'b0}}, precision, 1'b0});

    // shift-add multiplier, msb first, sign bit weighs negative
    assign addend  = mshift_reg[X_WIDTH-1] ? v_reg : '0;
    assign base    = cmd.mul_first ? '0 : {acc_reg[ACC_W-2:0], 1'b0};
    assign product = cmd.mul_first ? (base - addend) : (base + addend);

    // coefficient scaled to the product's fixed point
    always_comb
    begin
        unique case (cmd.coef_sel)
            COEF_SEL_SQUARE:
                term = $signed({{(ACC_W-COEF_WIDTH){coef_square[COEF_WIDTH-1]}},
                                coef_square}) <<< X_FRAC_BITS;
            COEF_SEL_LINEAR:
                term = $signed({{(ACC_W-COEF_WIDTH){coef_linear[COEF_WIDTH-1]}},
                                coef_linear}) <<< (2 * X_FRAC_BITS);
            COEF_SEL_CONST:
                term = $signed({{(ACC_W-COEF_WIDTH){coef_const[COEF_WIDTH-1]}},
                                coef_const}) <<< (3 * X_FRAC_BITS);
            default:
                term = '0;
        endcase
    end

    assign v_neg  = v_reg[ACC_W-1];
    assign v_zero = (v_reg == '0);

    // next-state of the datapath registers
    always_comb
    begin
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        mshift_next    = mshift_reg;
        v_next         = v_reg;
        acc_next       = acc_reg;
        steps_next     = steps_reg;
        exact_next     = exact_reg;
        out_root_next  = out_root_reg;
        out_exact_next = out_exact_reg;
        out_steps_next = out_steps_reg;

        if (cmd.load)
        begin
            lo_next    = left_end;
            hi_next    = right_end;
            steps_next = '0;
            exact_next = 1'b0;
        end

        if (cmd.step_start)
        begin
            mid_next    = half;
            mshift_next = half;
            steps_next  = steps_reg + STEP_W'(1);
            v_next      = $signed({{(ACC_W-COEF_WIDTH){coef_cubic[COEF_WIDTH-1]}},
                                   coef_cubic});
        end

        if (cmd.mul_bit)
        begin
            acc_next    = product;
            mshift_next = {mshift_reg[X_WIDTH-2:0], 1'b0};
        end

        if (cmd.add_coef)
        begin
            v_next      = acc_reg + term;
            mshift_next = mid_reg;
        end

        if (cmd.decide)
        begin
            if (v_neg)
                lo_next = mid_reg;
            else if (!v_zero)
                hi_next = mid_reg;
            else
                exact_next = 1'b1;
        end

        // with no step taken the result is the input midpoint
        if (cmd.publish)
        begin
            out_root_next  = (steps_reg == '0) ? half : mid_reg;
            out_exact_next = exact_reg;
            out_steps_next = steps_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        mshift_reg    <= mshift_next;
        v_reg         <= v_next;
        acc_reg       <= acc_next;
        steps_reg     <= steps_next;
        exact_reg     <= exact_next;
        out_root_reg  <= out_root_next;
        out_exact_reg <= out_exact_next;
        out_steps_reg <= out_steps_next;
    end

    assign sts.cont   = (span >= twice_eps);
    assign sts.v_zero = v_zero;

    assign root            = out_root_reg;
    assign exact_zero      = out_exact_reg;
    assign iterations_done = out_steps_reg;

endmodule : cbr_dpath

`default_nettype wire

### hdl/cbr_ctrl.sv
// cbr_ctrl: sequencer for bisection steps and the bit-serial horner passes
`timescale 1ns / 1ps
`default_nettype none

module cbr_ctrl #(
    parameter int X_WIDTH = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output cbr_pkg::cmd_t          cmd,
    input  wire cbr_pkg::status_t  sts
);
    import cbr_pkg::*;

    localparam int BIT_W = $clog2(X_WIDTH);
    localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(X_WIDTH - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_ADDC   = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    coef_sel_t        pass_reg, pass_next;
    logic             out_valid_reg, out_valid_next;

    // state transitions and datapath commands
    always_comb
    begin
        state_next = state_reg;
        bit_next   = bit_reg;
        pass_next  = pass_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.cont)
                begin
                    cmd.step_start = 1'b1;
                    bit_next       = BIT_TOP;
                    pass_next      = COEF_SEL_SQUARE;
                    state_next     = S_MUL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MUL:
            begin
                cmd.mul_bit   = 1'b1;
                cmd.mul_first = (bit_reg == BIT_TOP);
                if (bit_reg == '0)
                    state_next = S_ADDC;
                else
                    bit_next = bit_reg - BIT_W'(1);
            end
            S_ADDC:
            begin
                cmd.add_coef = 1'b1;
                cmd.coef_sel = pass_reg;
                if (pass_reg == COEF_SEL_CONST)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    pass_next  = pass_reg + 2'd1;
                    bit_next   = BIT_TOP;
                    state_next = S_MUL;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = sts.v_zero ? S_DONE : S_CHECK;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result valid flag of the output register
    always_comb
    begin
        if (cmd.publish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bit_reg       <= '0;
            pass_reg      <= COEF_SEL_SQUARE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_reg       <= bit_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule : cbr_ctrl

`default_nettype wire

### hdl/cbr_checker.sv
// cbr_checker: port-level assertions for the cubic bisection root finder, with its bind
`timescale 1ns / 1ps
`default_nettype none

module cbr_checker #(
    parameter int X_WIDTH = 32
) (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [X_WIDTH-1:0] root,
    input wire logic               exact_zero,
    input wire logic [5:0]         iterations_done
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(root)
                                    && $stable(exact_zero) && $stable(iterations_done))
        else $error("result changed while stalled");

    // one request at a time: no request taken right after another
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

    // every step halves the bracket, so the count stays within the word width
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> iterations_done <= 6'(X_WIDTH))
        else $error("iteration count out of range");

    // an exact zero needs at least one evaluated midpoint
    a_exact_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && exact_zero |-> iterations_done != 6'd0)
        else $error("exact zero without a step");

endmodule : cbr_checker

bind cubic_bisection_root_top cbr_checker #(
    .X_WIDTH (X_WIDTH)
) u_cbr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (bracket.valid),
    .in_ready        (bracket.ready),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .root            (result.root),
    .exact_zero      (result.exact_zero),
    .iterations_done (result.iterations_done)
);

`default_nettype wire

### bench/tb_top.sv
// tb_top: self-checking bench for the cubic bisection root finder
`timescale 1ns / 1ps

module tb_top;
    import cbr_pkg::*;

    localparam int     ONE          = 65536;
    localparam longint X_MIN        = -64'sd2147483648;
    localparam longint X_MAX        = 64'sd2147483647;
    localparam int     HOLD_CYCLES  = 5000;
    localparam int     TAIL_CYCLES  = 3400;
    localparam int     LIMIT_CYCLES = 10_000_000;

    typedef struct packed {
        logic signed [31:0] left_end;
        logic signed [31:0] right_end;
    } bracket_t;

    typedef struct packed {
        logic signed [31:0] root;
        logic               exact_zero;
        logic [5:0]         steps;
    } root_result_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_write;
    cfg_index_t          cfg_index;
    logic [30:0]         cfg_data;

    cbr_in_if  #(.X_WIDTH(32)) bracket_if ();
    cbr_out_if #(.X_WIDTH(32)) result_if ();

    cubic_bisection_root_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .bracket   (bracket_if),
        .result    (result_if),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // local copy of the registers
    logic signed [15:0] coef_cubic;
    logic signed [15:0] coef_square;
    logic signed [15:0] coef_linear;
    logic signed [15:0] coef_const;
    logic [30:0]        precision_reg;

    bracket_t     pending_brackets[$];
    root_result_t expected_roots[$];
    int           root_pts[3];
    int           send_idle_pct;
    int           recv_stall_pct;
    int           errors;
    int           cycle_count;
    int           hold_left;
    logic         hold_req;
    logic         hold_seen;

    always #1 clk = ~clk;

    // sign of p(m / 2^16) scaled by 2^48, exact
    function automatic int poly_sign(longint m);
        logic signed [127:0] acc;
        logic signed [127:0] mm;
        logic signed [127:0] sq;
        logic signed [127:0] lin;
        logic signed [127:0] cst;
        acc = coef_cubic;
        mm  = m;
        sq  = coef_square;
        lin = coef_linear;
        cst = coef_const;
        acc = acc * mm + (sq <<< 16);
        acc = acc * mm + (lin <<< 32);
        acc = acc * mm + (cst <<< 48);
        if (acc < 0)
            return -1;
        return (acc != 0) ? 1 : 0;
    endfunction

    // bisection of one bracket under the current registers
    function automatic root_result_t bisect(logic signed [31:0] left_end,
                                            logic signed [31:0] right_end);
        root_result_t res;
        longint       lo;
        longint       hi;
        longint       eps;
        longint       mid;
        int           steps;
        int           s;
        logic         exact;
        lo    = left_end;
        hi    = right_end;
        eps   = (precision_reg == 0) ? 1 : precision_reg;
        mid   = (lo + hi) >>> 1;
        steps = 0;
        exact = 1'b0;
        while (hi - lo >= 2 * eps)
        begin
            mid = (lo + hi) >>> 1;
            steps++;
            s = poly_sign(mid);
            if (s < 0)
                lo = mid;
            else if (s > 0)
                hi = mid;
            else
            begin
                exact = 1'b1;
                break;
            end
        end
        res.root       = mid[31:0];
        res.exact_zero = exact;
        res.steps      = steps[5:0];
        return res;
    endfunction

    // request driver
    always @(posedge clk)
    begin : drive_requests
        bracket_t item;
        if (!rst_n)
            bracket_if.valid <= 1'b0;
        else if (!bracket_if.valid || bracket_if.ready)
        begin
            if (pending_brackets.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                item = pending_brackets.pop_front();
                bracket_if.valid     <= 1'b1;
                bracket_if.left_end  <= item.left_end;
                bracket_if.right_end <= item.right_end;
            end
            else
                bracket_if.valid <= 1'b0;
        end
    end

    // long receiver hold-off, started once on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end
        else
        begin
            hold_seen <= hold_req;
            if (hold_req && !hold_seen)
                hold_left <= HOLD_CYCLES;
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
        end
    end

    // result ready with random stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            result_if.ready <= 1'b0;
        else
            result_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor: check results, then predict for accepted requests
    always @(posedge clk)
    begin : watch_results
        root_result_t want;
        if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
            begin
                if (expected_roots.size() == 0)
                begin
                    $error("result with no request pending: root %0d", result_if.root);
                    errors++;
                end
                else
                begin
                    want = expected_roots.pop_front();
                    if (result_if.root !== want.root)
                    begin
                        $error("root: expected %0d, got %0d", want.root, result_if.root);
                        errors++;
                    end
                    if (result_if.exact_zero !== want.exact_zero)
                    begin
                        $error("exact_zero: expected %0d, got %0d",
                               want.exact_zero, result_if.exact_zero);
                        errors++;
                    end
                    if (result_if.iterations_done !== want.steps)
                    begin
                        $error("iterations_done: expected %0d, got %0d",
                               want.steps, result_if.iterations_done);
                        errors++;
                    end
                end
            end
            if (bracket_if.valid && bracket_if.ready)
                expected_roots.push_back(bisect(bracket_if.left_end, bracket_if.right_end));
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic set_reg(cfg_index_t idx, logic [30:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_COEF_CUBIC:  coef_cubic    = data[15:0];
            REG_COEF_SQUARE: coef_square   = data[15:0];
            REG_COEF_LINEAR: coef_linear   = data[15:0];
            REG_COEF_CONST:  coef_const    = data[15:0];
            REG_PRECISION:   precision_reg = data;
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_coefs(logic signed [15:0] a, logic signed [15:0] b,
                             logic signed [15:0] c, logic signed [15:0] d);
        set_reg(REG_COEF_CUBIC,  {{15{a[15]}}, a});
        set_reg(REG_COEF_SQUARE, {{15{b[15]}}, b});
        set_reg(REG_COEF_LINEAR, {{15{c[15]}}, c});
        set_reg(REG_COEF_CONST,  {{15{d[15]}}, d});
    endtask

    task automatic push(logic signed [31:0] left_end, logic signed [31:0] right_end);
        bracket_t item;
        item.left_end  = left_end;
        item.right_end = right_end;
        pending_brackets.push_back(item);
    endtask

    // wait until every request is taken and every result has come back
    task automatic drain();
        do
            @(negedge clk);
        while (pending_brackets.size() != 0 || bracket_if.valid || expected_roots.size() != 0);
    endtask

    task automatic set_pace(int mode);
        case (mode)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 74;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 74;
            end
            default:
            begin
                send_idle_pct  = 25;
                recv_stall_pct = 25;
            end
        endcase
    endtask

    // cubic with known integer roots, or random coefficients when noisy, and a random precision
    task automatic rand_config(bit noisy);
        int           a;
        int           r1;
        int           r2;
        int           r3;
        int           shift;
        logic [30:0]  eps;
        r1 = $urandom_range(0, 12) - 6;
        r2 = $urandom_range(0, 12) - 6;
        r3 = $urandom_range(0, 12) - 6;
        root_pts[0] = r1;
        root_pts[1] = r2;
        root_pts[2] = r3;
        a = $urandom_range(1, 60);
        if ($urandom_range(0, 3) == 0)
            a = -a;
        if (noisy)
            set_coefs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        else
            set_coefs(16'(a), 16'(-a * (r1 + r2 + r3)),
                      16'(a * (r1 * r2 + r1 * r3 + r2 * r3)), 16'(-a * r1 * r2 * r3));
        shift = $urandom_range(0, 24);
        eps   = 31'(1 + ($urandom & ((32'd1 << shift) - 1)));
        set_reg(REG_PRECISION, eps);
    endtask

    // mostly brackets around a known root, some noise and degenerate ones
    task automatic push_random_bracket();
        longint root_q;
        longint eps;
        longint w;
        longint off;
        longint lo;
        longint hi;
        longint r32;
        int     kind;
        int     n;
        int     s1;
        int     s2;
        kind   = $urandom_range(0, 19);
        root_q = longint'(root_pts[$urandom_range(0, 2)]) * ONE;
        eps    = (precision_reg == 0) ? 1 : precision_reg;
        r32    = $urandom;
        if (kind < 12)
        begin
            // a few steps above the precision
            w = (2 * eps) << $urandom_range(0, 8);
            w = w + (r32 % w) / 2;
            if (w > 64'hFFFF_FFFF)
                w = 64'hFFFF_FFFF;
            r32 = $urandom;
            off = r32 % w;
            lo  = root_q - off;
            hi  = lo + w;
        end
        else if (kind < 17)
        begin
            // power-of-two width so the root lands on a midpoint
            n   = $urandom_range(1, 18);
            off = 1 + (r32 % ((64'sd1 << n) - 1));
            lo  = root_q - off;
            hi  = lo + (64'sd1 << n);
        end
        else if (kind < 18)
        begin
            s1 = $urandom;
            s2 = $urandom;
            lo = s1;
            hi = s2;
        end
        else
        begin
            // narrower than twice the precision, or reversed
            lo = root_q + (r32 % 2000) - 1000;
            if ($urandom_range(0, 1) == 1)
                hi = lo - $urandom_range(0, 5000);
            else
                hi = lo + (longint'($urandom) % (2 * eps));
        end
        if (lo < X_MIN)
            lo = X_MIN;
        if (lo > X_MAX)
            lo = X_MAX;
        if (hi < X_MIN)
            hi = X_MIN;
        if (hi > X_MAX)
            hi = X_MAX;
        push(lo[31:0], hi[31:0]);
    endtask

    // stimulus sequence
    initial
    begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_write            = 1'b0;
        cfg_index            = REG_COEF_CUBIC;
        cfg_data             = '0;
        bracket_if.valid     = 1'b0;
        bracket_if.left_end  = '0;
        bracket_if.right_end = '0;
        result_if.ready      = 1'b0;
        hold_req             = 1'b0;
        errors               = 0;
        cycle_count          = 0;
        coef_cubic           = '0;
        coef_square          = '0;
        coef_linear          = '0;
        coef_const           = '0;
        precision_reg        = 31'd1;
        set_pace(0);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: zero polynomial
        push(-ONE, ONE);
        push(5, 4);
        drain();

        // x^3 - x, finest precision
        set_coefs(1, 0, -1, 0);
        set_reg(REG_PRECISION, 31'd1);
        push(-2 * ONE, 2 * ONE);
        push(-ONE / 2, 3 * ONE / 4);
        push(ONE / 4, 3 * ONE / 2);
        push(ONE / 2, 3 * ONE / 4);
        push(32'sh8000_0000, 32'sh7fff_ffff);
        push(32'sh7fff_ffff, 32'sh8000_0000);
        push(32'sh8000_0000, 32'sh8000_0000);
        push(32'sh7fff_ffff, 32'sh7fff_ffff);
        push(100, 102);
        push(100, 101);
        drain();

        // coefficient extremes, widest precision
        set_coefs(-32768, 32767, -32768, 32767);
        set_reg(REG_PRECISION, 31'h7fff_ffff);
        push(32'sh8000_0000, 32'sh7fff_ffff);
        push(32'sh8000_0000, 32'sh7fff_fffe);
        push(32'sh8000_0001, 32'sh7fff_fffe);
        drain();

        // opposite extremes, precision zero acts as one
        set_coefs(32767, -32768, 32767, -32768);
        set_reg(REG_PRECISION, 31'd0);
        push(32'sh8000_0000, 32'sh7fff_ffff);
        push(-3 * ONE, 5 * ONE);
        push(0, 1);
        push(-1, 1);
        drain();

        // roots at 1, 2 and 3
        set_coefs(1, -6, 11, -6);
        set_reg(REG_PRECISION, 31'(ONE / 1024));
        push(ONE / 2, 2 * ONE);
        push(0, 4 * ONE);
        push(3 * ONE - 100, 3 * ONE + 100);
        drain();

        // random phases, two register settings per pacing mode
        for (int mode = 0; mode < 4; mode++)
        begin
            set_pace(mode);
            for (int sub = 0; sub < 2; sub++)
            begin
                rand_config(sub == 1 && mode >= 2);
                repeat (75) push_random_bracket();
                drain();
            end
        end

        // receiver holds off while requests keep coming
        set_pace(0);
        rand_config(1'b0);
        repeat (12) push_random_bracket();
        hold_req = 1'b1;
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule : tb_top

### filelist.f
hdl/cbr_pkg.sv
hdl/cbr_ifs.sv
hdl/cbr_regs.sv
hdl/cbr_dpath.sv
hdl/cbr_ctrl.sv
hdl/cubic_bisection_root_top.sv
hdl/cbr_checker.sv
bench/tb_top.sv
